// ===== rtl/core/rhsv_pkg.sv =====
package rhsv_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 15;
	localparam int SAT_W      = 17;
	localparam int SAT_FRAC   = 16;
	localparam int DIV_Q_W    = 18;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;
	localparam int DIVIDEND_W = CH_W + DIV_Q_W;
	localparam int PIPE_STAGES = DIV_STAGES + 2;

	localparam logic [11:0] SECTOR_64 = 12'd3840;

	localparam logic [HUE_W-1:0] HUE_BASE_RED   = 15'd0;
	localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_WRAP       = 15'd23040;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rhsv_rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [CH_W-1:0]  brightness;
	} rhsv_hsv_t;

	typedef struct packed {
		logic [CH_W-1:0]  brightness;
		logic [CH_W-1:0]  delta;
		logic [CH_W-1:0]  hue_num;
		logic [HUE_W-1:0] hue_base;
		logic             hue_neg;
		logic             gray;
	} rhsv_sort_t;

	typedef struct packed {
		logic [CH_W-1:0]  brightness;
		logic [HUE_W-1:0] hue_base;
		logic             hue_neg;
		logic             gray;
	} rhsv_side_t;

	typedef struct packed {
		logic [DIV_STEP-1:0] q;
		logic [CH_W-1:0]     rem;
	} rhsv_step_t;

	function automatic rhsv_step_t div_step(input logic [CH_W-1:0] rem,
			input logic [DIV_STEP-1:0] bits, input logic [CH_W-1:0] d);
		logic [CH_W:0] r;
		rhsv_step_t    res;
		r = {1'b0, rem};
		res.q = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			r = {r[CH_W-1:0], bits[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				res.q[i] = 1'b1;
			end
		end
		res.rem = r[CH_W-1:0];
		return res;
	endfunction

endpackage

// ===== rtl/core/rhsv_sort.sv =====
module rhsv_sort (
	input  logic                  clk,
	input  logic                  en,
	input  rhsv_pkg::rhsv_rgb_t   pix,
	output rhsv_pkg::rhsv_sort_t  sort_s1
);

	logic [rhsv_pkg::CH_W-1:0]  mx;
	logic [rhsv_pkg::CH_W-1:0]  mn;
	logic [rhsv_pkg::CH_W-1:0]  op_a;
	logic [rhsv_pkg::CH_W-1:0]  op_b;
	logic [rhsv_pkg::HUE_W-1:0] base_pos;
	logic [rhsv_pkg::HUE_W-1:0] base_neg;
	logic                       neg;
	rhsv_pkg::rhsv_sort_t       nxt;

	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			mx       = pix.red;
			op_a     = pix.green;
			op_b     = pix.blue;
			base_pos = rhsv_pkg::HUE_BASE_RED;
			base_neg = rhsv_pkg::HUE_WRAP;
		end else if (pix.green >= pix.blue) begin
			mx       = pix.green;
			op_a     = pix.blue;
			op_b     = pix.red;
			base_pos = rhsv_pkg::HUE_BASE_GREEN;
			base_neg = rhsv_pkg::HUE_BASE_GREEN;
		end else begin
			mx       = pix.blue;
			op_a     = pix.red;
			op_b     = pix.green;
			base_pos = rhsv_pkg::HUE_BASE_BLUE;
			base_neg = rhsv_pkg::HUE_BASE_BLUE;
		end

		mn = pix.red;
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.blue < mn) begin
			mn = pix.blue;
		end

		neg            = op_a < op_b;
		nxt.brightness = mx;
		nxt.delta      = mx - mn;
		nxt.hue_num    = neg ? (op_b - op_a) : (op_a - op_b);
		nxt.hue_base   = neg ? base_neg : base_pos;
		nxt.hue_neg    = neg;
		nxt.gray       = (mx == mn);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sort_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/core/rhsv_div.sv =====
module rhsv_div (
	input  logic                                clk,
	input  logic [rhsv_pkg::DIV_STAGES-1:0]     en,
	input  logic [rhsv_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [rhsv_pkg::CH_W-1:0]           divisor,
	output logic [rhsv_pkg::DIV_Q_W-1:0]        quotient,
	output logic                                rem_nz
);

	logic [rhsv_pkg::CH_W-1:0]    rem_s [rhsv_pkg::DIV_STAGES];
	logic [rhsv_pkg::CH_W-1:0]    d_s   [rhsv_pkg::DIV_STAGES];
	logic [rhsv_pkg::DIV_Q_W-1:0] lo_s  [rhsv_pkg::DIV_STAGES];
	logic [rhsv_pkg::DIV_Q_W-1:0] q_s   [rhsv_pkg::DIV_STAGES];

	for (genvar k = 0; k < rhsv_pkg::DIV_STAGES; k++) begin : g_stage
		logic [rhsv_pkg::CH_W-1:0]    rem_in;
		logic [rhsv_pkg::CH_W-1:0]    d_in;
		logic [rhsv_pkg::DIV_Q_W-1:0] lo_in;
		logic [rhsv_pkg::DIV_Q_W-1:0] q_in;
		rhsv_pkg::rhsv_step_t         st;

		if (k == 0) begin : g_first
			assign rem_in = dividend[rhsv_pkg::DIVIDEND_W-1 -: rhsv_pkg::CH_W];
			assign lo_in  = dividend[rhsv_pkg::DIV_Q_W-1:0];
			assign q_in   = '0;
			assign d_in   = divisor;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
		end

		assign st = rhsv_pkg::div_step(rem_in,
			lo_in[rhsv_pkg::DIV_Q_W-1 -: rhsv_pkg::DIV_STEP], d_in);

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= st.rem;
				d_s[k]   <= d_in;
				lo_s[k]  <= lo_in << rhsv_pkg::DIV_STEP;
				q_s[k]   <= {q_in[rhsv_pkg::DIV_Q_W-rhsv_pkg::DIV_STEP-1:0], st.q};
			end
		end
	end

	assign quotient = q_s[rhsv_pkg::DIV_STAGES-1];
	assign rem_nz   = |rem_s[rhsv_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/rgb_to_hsv_pixel_converter.sv =====
// RGB to HSV converter, one pixel per clock while the output is not stalled.
// A pixel passes a stage that finds the largest and smallest channel, the
// stages of two parallel pipelined dividers that each resolve three quotient
// bits per stage, and an output register. Brightness is the
// largest channel, saturation is (max-min)/max with 16 fractional bits (0 for
// black), hue is degrees times 64, floored, and 0 for gray pixels. Each stage
// advances whenever the stage after it is empty or moving, so bubbles close
// up and a stalled result does not block new pixels until the pipeline fills.
module rgb_to_hsv_pixel_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  rhsv_pkg::rhsv_rgb_t  pix,
	output logic                 hsv_valid,
	input  logic                 hsv_stall,
	output rhsv_pkg::rhsv_hsv_t  hsv
);

	localparam int LAST = rhsv_pkg::PIPE_STAGES - 1;
	localparam int DLAST = rhsv_pkg::DIV_STAGES - 1;

	logic [rhsv_pkg::PIPE_STAGES-1:0] valid_q;
	logic [rhsv_pkg::PIPE_STAGES-1:0] move;

	rhsv_pkg::rhsv_sort_t sort_s1;
	rhsv_pkg::rhsv_side_t side_s [rhsv_pkg::DIV_STAGES];
	rhsv_pkg::rhsv_side_t side_last;
	rhsv_pkg::rhsv_hsv_t  hsv_q;
	rhsv_pkg::rhsv_hsv_t  hsv_nxt;

	logic [rhsv_pkg::DIVIDEND_W-1:0] hue_dividend;
	logic [rhsv_pkg::DIVIDEND_W-1:0] sat_dividend;
	logic [rhsv_pkg::DIV_Q_W-1:0]    hue_quot;
	logic [rhsv_pkg::DIV_Q_W-1:0]    sat_quot;
	logic                            hue_rem_nz;
	logic                            sat_rem_nz;
	logic [rhsv_pkg::HUE_W-1:0]      hue_term;

	always_comb begin
		move[LAST] = !valid_q[LAST] || !hsv_stall;
		for (int k = LAST - 1; k >= 0; k--) begin
			move[k] = !valid_q[k] || move[k+1];
		end
	end

	assign pix_stall = !move[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (move[0]) begin
				valid_q[0] <= pix_valid;
			end
			for (int k = 1; k <= LAST; k++) begin
				if (move[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	rhsv_sort u_sort (
		.clk     (clk),
		.en      (move[0]),
		.pix     (pix),
		.sort_s1 (sort_s1)
	);

	assign hue_dividend = rhsv_pkg::DIVIDEND_W'(sort_s1.hue_num)
		* rhsv_pkg::DIVIDEND_W'(rhsv_pkg::SECTOR_64);
	assign sat_dividend = rhsv_pkg::DIVIDEND_W'(sort_s1.delta) << rhsv_pkg::SAT_FRAC;

	rhsv_div u_hue_div (
		.clk      (clk),
		.en       (move[LAST-1:1]),
		.dividend (hue_dividend),
		.divisor  (sort_s1.delta),
		.quotient (hue_quot),
		.rem_nz   (hue_rem_nz)
	);

	rhsv_div u_sat_div (
		.clk      (clk),
		.en       (move[LAST-1:1]),
		.dividend (sat_dividend),
		.divisor  (sort_s1.brightness),
		.quotient (sat_quot),
		.rem_nz   (sat_rem_nz)
	);

	for (genvar k = 0; k < rhsv_pkg::DIV_STAGES; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (move[1]) begin
					side_s[0].brightness <= sort_s1.brightness;
					side_s[0].hue_base   <= sort_s1.hue_base;
					side_s[0].hue_neg    <= sort_s1.hue_neg;
					side_s[0].gray       <= sort_s1.gray;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (move[k+1]) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign side_last = side_s[DLAST];

	always_comb begin
		hue_term = hue_quot[rhsv_pkg::HUE_W-1:0];
		if (side_last.gray) begin
			hsv_nxt.hue = '0;
		end else if (side_last.hue_neg) begin
			hsv_nxt.hue = side_last.hue_base
				- (hue_term + rhsv_pkg::HUE_W'(hue_rem_nz));
		end else begin
			hsv_nxt.hue = side_last.hue_base + hue_term;
		end
		if (side_last.brightness == '0) begin
			hsv_nxt.saturation = '0;
		end else begin
			hsv_nxt.saturation = sat_quot[rhsv_pkg::SAT_W-1:0]
				| {rhsv_pkg::SAT_W{1'b0 & sat_rem_nz}};
		end
		hsv_nxt.brightness = side_last.brightness;
	end

	always_ff @(posedge clk) begin
		if (move[LAST]) begin
			hsv_q <= hsv_nxt;
		end
	end

	assign hsv_valid = valid_q[LAST];
	assign hsv       = hsv_q;

endmodule
